// ----- sv/dssf_pkg.sv -----
// ----------------------------------------------------------------------------
// dssf_pkg
// Shared widths, limits, types and helpers for the density spike and step
// flagger.
// ----------------------------------------------------------------------------
package dssf_pkg;

  // Largest number of levels in one profile that gets its own index.
  localparam int MAX_LEVELS = 1024;

  localparam int DIFF_W  = 32;   // signed Q11.20 density difference
  localparam int RATIO_W = 16;   // unsigned Q4.12 spike multiplier
  localparam int LEVEL_W = 10;   // level index width
  localparam int RATIO_FRAC = 12;

  // The level index saturates at the smaller of MAX_LEVELS-1 and the
  // largest value the index field can carry.
  localparam int INDEX_CAP_INT = (MAX_LEVELS - 1 < (1 << LEVEL_W) - 1) ?
                                 MAX_LEVELS - 1 : (1 << LEVEL_W) - 1;
  localparam logic [LEVEL_W-1:0] INDEX_CAP = LEVEL_W'(INDEX_CAP_INT);

  // Comparison results for one pair of neighboring differences.
  typedef struct packed {
    logic a_below;     // lower difference is below tolerance
    logic d_below;     // upper difference is below tolerance
    logic ratio_hit;   // |a+d| * 1.0 < ratio * |a-d|
  } cmp_t;

  // One result word.
  typedef struct packed {
    logic [LEVEL_W-1:0] level_index;
    logic               reject;
    logic               spike;
    logic               step;
    logic               last_result;
  } result_t;

  // Saturating increment of a level number.
  function automatic logic [LEVEL_W-1:0] sat_inc(input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] r;
    if (lvl >= INDEX_CAP) begin
      r = INDEX_CAP;
    end else begin
      r = lvl + LEVEL_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- sv/density_spike_step_flagger.sv -----
// ----------------------------------------------------------------------------
// density_spike_step_flagger
// Flags density spikes and steps level by level from a stream of one
// profile's level-to-level density differences.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ---------------------------------
//  in       input      in_valid / in_stall  dens_delta, diff_missing,
//                                           upper_prior_spike, last_in_profile
//  out      output     out_valid/out_stall  level_index, reject, spike, step,
//                                           last_result
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// An accepted word lands in an input register; the comparison logic evaluates
// it against the stored neighbor and loads every result it causes into a
// three-entry result register. Unless stalled, it drains one word a cycle and
// a steady profile takes one word per cycle; a profile's last word yields
// three results and so holds the input until they drain, and a single-word
// profile yields two. The result register is the only thing that sets this.
// Reset is synchronous; it restores the register defaults and clears the
// profile state. A stall on the output backs up into in_stall as soon as the
// input register holds a word that the result register cannot take yet.
//
module density_spike_step_flagger import dssf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DIFF_W-1:0]  dens_delta,
  input  logic                      diff_missing,
  input  logic                      upper_prior_spike,
  input  logic                      last_in_profile,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic        [LEVEL_W-1:0] level_index,
  output logic                      reject,
  output logic                      spike,
  output logic                      step,
  output logic                      last_result,

  input  logic                      cfg_we,
  input  logic        [1:0]         cfg_index,
  input  logic        [DIFF_W-1:0]  cfg_data
);

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPIKE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_STEP_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE    = 2'd2;
  localparam logic [1:0] CFG_SPIKE_RATIO  = 2'd3;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1 << RATIO_FRAC);

  // Configuration registers.
  logic                     spike_enable;
  logic                     step_enable;
  logic signed [DIFF_W-1:0] tolerance;
  logic        [RATIO_W-1:0] spike_ratio;

  // Input register.
  logic                     ir_valid;
  logic signed [DIFF_W-1:0] ir_diff;
  logic                     ir_missing;
  logic                     ir_prior;
  logic                     ir_last;

  // Profile state, carried from one difference to the next.
  logic                     started;
  logic signed [DIFF_W-1:0] prev_diff;
  logic                     prev_missing;
  logic                     prev_prior_spike;
  logic                     spike_just_found;
  logic                     pending_reject;
  logic                     pending_spike;
  logic                     pending_step;
  logic        [LEVEL_W-1:0] level_count;

  logic                     started_next;
  logic signed [DIFF_W-1:0] prev_diff_next;
  logic                     prev_missing_next;
  logic                     prev_prior_spike_next;
  logic                     spike_just_found_next;
  logic                     pending_reject_next;
  logic                     pending_spike_next;
  logic                     pending_step_next;
  logic        [LEVEL_W-1:0] level_count_next;

  // Result register: up to three words, the head always in entry zero.
  result_t                  res [3];
  logic        [1:0]        res_cnt;
  result_t                  new_res [3];
  logic        [1:0]        new_cnt;

  logic                     burst_free;
  logic                     process;
  logic                     in_accept;
  logic                     out_pop;

  cmp_t                     cmp;
  logic                     spike_new;
  logic                     step_new;
  logic                     final_step;
  logic        [LEVEL_W-1:0] lc_plus1;
  logic        [LEVEL_W-1:0] lc_plus2;

  dssf_spike_cmp u_cmp (
    .a           (prev_diff),
    .d           (ir_diff),
    .tolerance   (tolerance),
    .spike_ratio (spike_ratio),
    .cmp         (cmp)
  );

  // Handshakes. The result register can take a new burst when it is empty
  // or its final word leaves this cycle.
  assign out_valid  = res_cnt != 2'd0;
  assign out_pop    = out_valid && !out_stall;
  assign burst_free = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && !out_stall);
  assign process    = ir_valid && burst_free;
  assign in_stall   = ir_valid && !process;
  assign in_accept  = in_valid && !in_stall;

  assign level_index = res[0].level_index;
  assign reject      = res[0].reject;
  assign spike       = res[0].spike;
  assign step        = res[0].step;
  assign last_result = res[0].last_result;

  // Flag decisions for the difference in the input register. A spike needs
  // both neighbors present, one of them below tolerance, and is blocked on
  // level one and right above a spike found one level lower.
  assign spike_new = spike_enable && !spike_just_found && (level_count != '0) &&
                     !prev_missing && !ir_missing &&
                     (cmp.a_below || cmp.d_below) && cmp.ratio_hit;
  assign step_new  = step_enable && !(prev_prior_spike || spike_new) &&
                     !prev_missing && cmp.a_below;
  // At the final difference only the upper level can be flagged by a step.
  assign final_step = step_enable && !ir_prior && !ir_missing && cmp.d_below;

  assign lc_plus1 = sat_inc(level_count);
  assign lc_plus2 = sat_inc(lc_plus1);

  always_comb begin
    started_next          = started;
    prev_diff_next        = prev_diff;
    prev_missing_next     = prev_missing;
    prev_prior_spike_next = prev_prior_spike;
    spike_just_found_next = spike_just_found;
    pending_reject_next   = pending_reject;
    pending_spike_next    = pending_spike;
    pending_step_next     = pending_step;
    level_count_next      = level_count;
    new_cnt               = 2'd0;
    for (int i = 0; i < 3; i++) begin
      new_res[i] = '0;
    end

    if (!started) begin
      if (ir_last) begin
        // A profile of a single difference: two unflagged levels.
        new_res[0] = '{level_index: level_count, reject: 1'b0, spike: 1'b0,
                       step: 1'b0, last_result: 1'b0};
        new_res[1] = '{level_index: lc_plus1, reject: 1'b0, spike: 1'b0,
                       step: 1'b0, last_result: 1'b1};
        new_cnt    = 2'd2;
      end else begin
        started_next          = 1'b1;
        prev_diff_next        = ir_diff;
        prev_missing_next     = ir_missing;
        prev_prior_spike_next = ir_prior;
        spike_just_found_next = 1'b0;
      end
    end else begin
      // The lower level of the pair is finished now.
      new_res[0] = '{level_index: level_count,
                     reject: pending_reject || step_new,
                     spike: pending_spike, step: pending_step,
                     last_result: 1'b0};
      if (ir_last) begin
        new_res[1] = '{level_index: lc_plus1, reject: spike_new || step_new,
                       spike: spike_new, step: step_new, last_result: 1'b0};
        new_res[2] = '{level_index: lc_plus2, reject: final_step, spike: 1'b0,
                       step: final_step, last_result: 1'b1};
        new_cnt    = 2'd3;
      end else begin
        new_cnt               = 2'd1;
        level_count_next      = lc_plus1;
        pending_reject_next   = spike_new || step_new;
        pending_spike_next    = spike_new;
        pending_step_next     = step_new;
        spike_just_found_next = spike_new;
        prev_diff_next        = ir_diff;
        prev_missing_next     = ir_missing;
        prev_prior_spike_next = ir_prior;
      end
    end

    // The profile's last difference returns the profile state to its start.
    if (ir_last) begin
      started_next          = 1'b0;
      prev_diff_next        = '0;
      prev_missing_next     = 1'b1;
      prev_prior_spike_next = 1'b0;
      spike_just_found_next = 1'b0;
      pending_reject_next   = 1'b0;
      pending_spike_next    = 1'b0;
      pending_step_next     = 1'b0;
      level_count_next      = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      spike_enable <= 1'b1;
      step_enable  <= 1'b1;
      tolerance    <= '0;
      spike_ratio  <= RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPIKE_ENABLE: spike_enable <= cfg_data[0];
        CFG_STEP_ENABLE:  step_enable  <= cfg_data[0];
        CFG_TOLERANCE:    tolerance    <= cfg_data;
        CFG_SPIKE_RATIO:  spike_ratio  <= cfg_data[RATIO_W-1:0];
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_accept) begin
      ir_valid <= 1'b1;
    end else if (process) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ir_diff    <= dens_delta;
      ir_missing <= diff_missing;
      ir_prior   <= upper_prior_spike;
      ir_last    <= last_in_profile;
    end
  end

  // Profile state advances once per evaluated difference.
  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      prev_diff        <= '0;
      prev_missing     <= 1'b1;
      prev_prior_spike <= 1'b0;
      spike_just_found <= 1'b0;
      pending_reject   <= 1'b0;
      pending_spike    <= 1'b0;
      pending_step     <= 1'b0;
      level_count      <= '0;
    end else if (process) begin
      started          <= started_next;
      prev_diff        <= prev_diff_next;
      prev_missing     <= prev_missing_next;
      prev_prior_spike <= prev_prior_spike_next;
      spike_just_found <= spike_just_found_next;
      pending_reject   <= pending_reject_next;
      pending_spike    <= pending_spike_next;
      pending_step     <= pending_step_next;
      level_count      <= level_count_next;
    end
  end

  // Result register count.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (process) begin
      res_cnt <= new_cnt;
    end else if (out_pop) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  // Result words: a new burst loads all entries, a taken word shifts them.
  always_ff @(posedge clk) begin
    if (process) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= new_res[i];
      end
    end else if (out_pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

endmodule

// ----- sv/dssf_spike_cmp.sv -----
// ----------------------------------------------------------------------------
// dssf_spike_cmp
// Tolerance compares and the exact spike ratio test for two neighboring
// density differences.
// ----------------------------------------------------------------------------
module dssf_spike_cmp import dssf_pkg::*; (
  input  logic signed [DIFF_W-1:0]  a,
  input  logic signed [DIFF_W-1:0]  d,
  input  logic signed [DIFF_W-1:0]  tolerance,
  input  logic        [RATIO_W-1:0] spike_ratio,
  output cmp_t                      cmp
);

  localparam int SUM_W = DIFF_W + 1;
  localparam int LHS_W = SUM_W + RATIO_FRAC;
  localparam int RHS_W = SUM_W + RATIO_W;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] dif;
  logic        [SUM_W-1:0] abs_sum;
  logic        [SUM_W-1:0] abs_dif;
  logic        [LHS_W-1:0] lhs;
  logic        [RHS_W-1:0] rhs;

  // Sums are one bit wider so that neither can overflow.
  assign sum = {a[DIFF_W-1], a} + {d[DIFF_W-1], d};
  assign dif = {a[DIFF_W-1], a} - {d[DIFF_W-1], d};

  // The magnitude of the most negative sum still fits as an unsigned value.
  assign abs_sum = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  assign abs_dif = dif[SUM_W-1] ? (~dif + SUM_W'(1)) : dif;

  assign lhs = {abs_sum, {RATIO_FRAC{1'b0}}};
  assign rhs = RHS_W'(spike_ratio) * RHS_W'(abs_dif);

  assign cmp.a_below   = a < tolerance;
  assign cmp.d_below   = d < tolerance;
  assign cmp.ratio_hit = CMP_W'(lhs) < CMP_W'(rhs);

endmodule

// ----- verif/dssf_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// dssf_tb_pkg
// Register names and the level-flag predictor with its store of expected
// result words for the density spike and step flagger testbench.
// ----------------------------------------------------------------------------
package dssf_tb_pkg;
  import dssf_pkg::*;

  typedef enum logic [1:0] {
    REG_SPIKE_EN  = 2'd0,
    REG_STEP_EN   = 2'd1,
    REG_TOLERANCE = 2'd2,
    REG_RATIO     = 2'd3
  } cfg_reg_e;

  class level_flag_board;
    // Register copies.
    bit                        spike_on;
    bit                        step_on;
    logic signed [DIFF_W-1:0]  tol;
    logic        [RATIO_W-1:0] ratio;

    // Profile state.
    logic signed [DIFF_W-1:0]  lower_diff;
    bit                        lower_missing;
    bit                        lower_prior;
    bit                        spike_fresh;
    bit                        hold_reject;
    bit                        hold_spike;
    bit                        hold_step;
    bit                        in_profile;
    logic        [LEVEL_W-1:0] level;

    result_t expected_levels[$];
    int      mismatches;

    function new();
      spike_on   = 1'b1;
      step_on    = 1'b1;
      tol        = '0;
      ratio      = RATIO_W'(4096);
      mismatches = 0;
      clear_profile();
    endfunction

    function void clear_profile();
      lower_diff    = '0;
      lower_missing = 1'b1;
      lower_prior   = 1'b0;
      spike_fresh   = 1'b0;
      hold_reject   = 1'b0;
      hold_spike    = 1'b0;
      hold_step     = 1'b0;
      in_profile    = 1'b0;
      level         = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [DIFF_W-1:0] v);
      case (idx)
        REG_SPIKE_EN:  spike_on = v[0];
        REG_STEP_EN:   step_on  = v[0];
        REG_TOLERANCE: tol      = v;
        REG_RATIO:     ratio    = v[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] cap_level(int x);
      return (x < INDEX_CAP_INT) ? LEVEL_W'(x) : INDEX_CAP;
    endfunction

    function void push_level(logic [LEVEL_W-1:0] idx, bit rej, bit spk, bit stp,
                             bit lst);
      result_t r;
      r.level_index = idx;
      r.reject      = rej;
      r.spike       = spk;
      r.step        = stp;
      r.last_result = lst;
      expected_levels.push_back(r);
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // Works out the levels that one accepted difference word releases.
    function void note_diff(logic signed [DIFF_W-1:0] d, bit mis, bit pr, bit lst);
      logic signed [DIFF_W-1:0] a;
      longint sum_ab, dif_ab;
      bit spike_new, step_new, top_step;

      if (!in_profile) begin
        if (lst) begin
          // A one-difference profile only names its two levels.
          push_level(cap_level(int'(level)), 1'b0, 1'b0, 1'b0, 1'b0);
          push_level(cap_level(int'(level) + 1), 1'b0, 1'b0, 1'b0, 1'b1);
          clear_profile();
        end else begin
          in_profile    = 1'b1;
          lower_diff    = d;
          lower_missing = mis;
          lower_prior   = pr;
          spike_fresh   = 1'b0;
        end
        return;
      end

      a = lower_diff;
      spike_new = 1'b0;
      if (spike_on && !spike_fresh && level >= 1 && !lower_missing && !mis &&
          (a < tol || d < tol)) begin
        sum_ab = longint'(a) + longint'(d);
        dif_ab = longint'(a) - longint'(d);
        if (sum_ab < 0) sum_ab = -sum_ab;
        if (dif_ab < 0) dif_ab = -dif_ab;
        spike_new = (sum_ab * (longint'(1) << RATIO_FRAC)) < (longint'(ratio) * dif_ab);
      end
      step_new = step_on && !(lower_prior || spike_new) && !lower_missing && a < tol;

      push_level(level, hold_reject || step_new, hold_spike, hold_step, 1'b0);
      level = cap_level(int'(level) + 1);

      hold_reject = spike_new || step_new;
      hold_spike  = spike_new;
      hold_step   = step_new;
      spike_fresh = spike_new;

      if (lst) begin
        // At the top only the upper level of a step is rejected.
        top_step = step_on && !pr && !mis && d < tol;
        push_level(level, hold_reject, hold_spike, hold_step, 1'b0);
        push_level(cap_level(int'(level) + 1), top_step, 1'b0, top_step, 1'b1);
        clear_profile();
        return;
      end

      lower_diff    = d;
      lower_missing = mis;
      lower_prior   = pr;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_level(result_t got);
      result_t want;
      if (expected_levels.size() == 0) begin
        report($sformatf("unexpected word level_index=%0d", got.level_index));
        return;
      end
      want = expected_levels.pop_front();
      if (got.level_index != want.level_index)
        report($sformatf("level_index got %0d want %0d", got.level_index,
                         want.level_index));
      if (got.reject != want.reject)
        report($sformatf("level %0d reject got %0b want %0b", want.level_index,
                         got.reject, want.reject));
      if (got.spike != want.spike)
        report($sformatf("level %0d spike got %0b want %0b", want.level_index,
                         got.spike, want.spike));
      if (got.step != want.step)
        report($sformatf("level %0d step got %0b want %0b", want.level_index,
                         got.step, want.step));
      if (got.last_result != want.last_result)
        report($sformatf("level %0d last_result got %0b want %0b", want.level_index,
                         got.last_result, want.last_result));
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the density spike and step flagger against a level-flag predictor:
// directed profiles for the corner cases, then random profiles under several
// register settings, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top import dssf_pkg::*, dssf_tb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DIFF_W-1:0] dens_delta;
  logic                     diff_missing;
  logic                     upper_prior_spike;
  logic                     last_in_profile;
  logic                     out_valid;
  logic                     out_stall;
  logic       [LEVEL_W-1:0] level_index;
  logic                     reject;
  logic                     spike;
  logic                     step;
  logic                     last_result;
  logic                     cfg_we;
  logic               [1:0] cfg_index;
  logic        [DIFF_W-1:0] cfg_data;

  level_flag_board board = new();

  // Idling switches; each phase decides whether either side may pause.
  bit gaps_on;
  bit stalls_on;
  int words_sent;

  density_spike_step_flagger i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .dens_delta        (dens_delta),
    .diff_missing      (diff_missing),
    .upper_prior_spike (upper_prior_spike),
    .last_in_profile   (last_in_profile),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .level_index       (level_index),
    .reject            (reject),
    .spike             (spike),
    .step              (step),
    .last_result       (last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The testbench drives at the falling edge and looks at the rising edge, so
  // what it samples is always the value that the block itself sees.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      board.note_diff(dens_delta, diff_missing, upper_prior_spike, last_in_profile);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_level('{level_index, reject, spike, step, last_result});
    end
  end

  // Receiver stalls come in bursts of random length while they are enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Presents one word and holds it until the block takes it. The sender may
  // first idle for a random gap.
  task send_word(input logic [DIFF_W-1:0] d, input bit mis, input bit pr,
                 input bit lst);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    dens_delta        = d;
    diff_missing      = mis;
    upper_prior_spike = pr;
    last_in_profile   = lst;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every expected level has come out.
  task wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // A register is only touched when nothing is in flight. The first word of a
  // profile yields no level, so run_phase also idles after the store empties.
  task write_reg(input cfg_reg_e idx, input logic [DIFF_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_reg(idx, v);
  endtask

  // Differences are mostly small values near zero or near the
  // negation of the one before, which is where spikes and steps live.
  function automatic logic [DIFF_W-1:0] pick_diff(input logic [DIFF_W-1:0] prev_d);
    logic [DIFF_W-1:0] v;
    logic [DIFF_W-1:0] noise;
    noise = $urandom_range(0, 4096) - 2048;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      2, 3, 4, 5: v = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      default: v = 32'h0 - prev_d + noise;
    endcase
    return v;
  endfunction

  task send_profile(input int len);
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] prev_d;
    prev_d = '0;
    for (int i = 0; i < len; i++) begin
      d = pick_diff(prev_d);
      send_word(d, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, i == len - 1);
      prev_d = d;
    end
  endtask

  // One random phase: program all four registers, then send whole profiles
  // until at least 45 words have gone in. A long profile, when asked for,
  // drives the level index into saturation.
  task run_phase(input bit spk_en, input bit stp_en, input logic [DIFF_W-1:0] tol_v,
                 input logic [RATIO_W-1:0] ratio_v, input bit gaps, input bit stalls,
                 input bit long_one);
    int start;
    int len;
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(REG_SPIKE_EN, DIFF_W'(spk_en));
    write_reg(REG_STEP_EN, DIFF_W'(stp_en));
    write_reg(REG_TOLERANCE, tol_v);
    write_reg(REG_RATIO, DIFF_W'(ratio_v));
    gaps_on   = gaps;
    stalls_on = stalls;
    start = words_sent;
    if (long_one) send_profile(1030);
    start = words_sent;
    while (words_sent - start < 45) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      send_profile(len);
    end
    stop_sending();
  endtask

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    dens_delta        = '0;
    diff_missing      = 1'b0;
    upper_prior_spike = 1'b0;
    last_in_profile   = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_SPIKE_EN;
    cfg_data          = '0;
    gaps_on           = 1'b1;
    stalls_on         = 1'b1;
    words_sent        = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed profiles under the reset register values: tolerance zero and
    // a ratio of one.
    // Short profiles with a single difference, one of them missing.
    send_word(32'h0000_0000, 1'b0, 1'b0, 1'b1);
    send_word(32'h8000_0000, 1'b1, 1'b1, 1'b1);
    // Spike at level two, then blocked on the level right above it.
    send_word(32'd100, 1'b0, 1'b0, 1'b0);
    send_word(-32'sd1000, 1'b0, 1'b0, 1'b0);
    send_word(32'd1000, 1'b0, 1'b0, 1'b0);
    send_word(-32'sd1000, 1'b0, 1'b0, 1'b0);
    send_word(32'd500, 1'b0, 1'b0, 1'b1);
    // No spike at the first check, extreme values, and a step at the top.
    send_word(-32'sd1000, 1'b0, 1'b0, 1'b0);
    send_word(32'd1000, 1'b0, 1'b0, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_word(-32'sd5, 1'b0, 1'b0, 1'b1);
    // Missing values and prior spikes; the sender also waits mid-profile
    // until every level so far has come out.
    send_word(-32'sd3, 1'b1, 1'b0, 1'b0);
    send_word(-32'sd3, 1'b0, 1'b1, 1'b0);
    stop_sending();
    wait_drained();
    send_word(32'h8000_0000, 1'b0, 1'b0, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
    send_word(-32'sd1, 1'b0, 1'b1, 1'b1);
    // Two-difference profiles: a step on both levels, and a missing top.
    send_word(-32'sd7, 1'b0, 1'b0, 1'b0);
    send_word(-32'sd7, 1'b0, 1'b0, 1'b1);
    send_word(32'd5, 1'b0, 1'b0, 1'b0);
    send_word(-32'sd9, 1'b1, 1'b0, 1'b1);
    stop_sending();

    // Random phases, extremes among the settings. A zero ratio must never
    // give a spike; the lowest tolerance never lets anything be below it.
    run_phase(1'b1, 1'b1, 32'h0010_0000, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    run_phase(1'b0, 1'b1, 32'hFFF0_0000, 16'd4096, 1'b1, 1'b0, 1'b0);
    run_phase(1'b1, 1'b0, 32'h7FFF_FFFF, 16'd0, 1'b0, 1'b1, 1'b0);
    run_phase(1'b1, 1'b1, 32'h8000_0000, 16'd8192, 1'b1, 1'b1, 1'b0);
    run_phase(1'b1, 1'b1, 32'h0000_0000, 16'd2048, 1'b1, 1'b1, 1'b0);
    // The last part runs with no idling on either side.
    run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
              RATIO_W'($urandom_range(0, 65535)), 1'b0, 1'b0, 1'b0);
    stop_sending();

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
